// ===== sv/rcpp_pkg.sv =====
// shared types and constants of the rtcp compound packet parser
package rcpp_pkg;

	localparam int OFFSET_W = 18;

	localparam logic [7:0] SR_CODE_RST = 8'd200;
	localparam logic [7:0] SD_CODE_RST = 8'd202;

	localparam logic CFG_IDX_SR = 1'b0;
	localparam logic CFG_IDX_SD = 1'b1;

	typedef struct packed {
		logic [7:0]  header;
		logic [7:0]  ptype;
		logic [15:0] len;
		logic [31:0] ssrc;
		logic [63:0] ntp;
		logic [31:0] rtp;
		logic [31:0] pkts;
		logic [31:0] octs;
		logic [7:0]  item;
		logic        truncated;
	} packet_rec_t;

	typedef struct packed {
		logic [1:0]  version;
		logic        padding;
		logic [4:0]  report_count;
		logic [7:0]  packet_type;
		logic [15:0] length_words;
		logic [31:0] ssrc;
		logic [63:0] ntp_timestamp;
		logic [31:0] rtp_timestamp;
		logic [31:0] sender_packets;
		logic [31:0] sender_octets;
		logic [7:0]  sdes_item_type;
		logic        truncated;
	} result_t;

endpackage

// ===== sv/rcpp_front.sv =====
// front end: takes payload bytes and gathers the fields of one packet
module rcpp_front import rcpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        rec_push,
	output packet_rec_t rec
);

	logic [OFFSET_W-1:0] off_q;
	packet_rec_t         acc_q;
	packet_rec_t         acc_d;
	logic [15:0]         len_now;
	logic                done;
	logic [1:0]          idx4;
	logic [2:0]          idx8;

	always_comb begin
		acc_d = acc_q;
		idx4  = 2'd3 - off_q[1:0];
		idx8  = 3'd7 - off_q[2:0];
		if (off_q == OFFSET_W'(0)) begin
			acc_d.header = data_byte;
		end else if (off_q == OFFSET_W'(1)) begin
			acc_d.ptype = data_byte;
		end else if (off_q == OFFSET_W'(2)) begin
			acc_d.len[15:8] = data_byte;
		end else if (off_q == OFFSET_W'(3)) begin
			acc_d.len[7:0] = data_byte;
		end else if (off_q inside {[4:7]}) begin
			acc_d.ssrc[idx4*8 +: 8] = data_byte;
		end else if (off_q inside {[8:15]}) begin
			acc_d.ntp[idx8*8 +: 8] = data_byte;
		end else if (off_q inside {[16:19]}) begin
			acc_d.rtp[idx4*8 +: 8] = data_byte;
		end else if (off_q inside {[20:23]}) begin
			acc_d.pkts[idx4*8 +: 8] = data_byte;
		end else if (off_q inside {[24:27]}) begin
			acc_d.octs[idx4*8 +: 8] = data_byte;
		end
		if (off_q == OFFSET_W'(8)) begin
			acc_d.item = data_byte;
		end
		len_now = acc_d.len;
		done    = (off_q >= OFFSET_W'(3)) && (off_q == {len_now, 2'b11});
		acc_d.truncated = ~done;
	end

	assign rec_push = accept && (done || end_of_buffer);
	assign rec      = acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			if (done || end_of_buffer) begin
				off_q <= '0;
				acc_q <= '0;
			end else begin
				off_q <= off_q + OFFSET_W'(1);
				acc_q <= acc_d;
			end
		end
	end

endmodule

// ===== sv/rcpp_queue.sv =====
// short queue of finished packet records between front and back end
module rcpp_queue import rcpp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  packet_rec_t wr_data,
	input  logic        rd,
	output packet_rec_t rd_data,
	output logic        not_empty,
	output logic        is_full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	packet_rec_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = count_q != CNT_W'(0);
	assign is_full   = count_q == CNT_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/rcpp_back.sv =====
// back end: classifies a packet record and holds the result word
module rcpp_back import rcpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  packet_rec_t rec,
	output logic        rec_take,
	input  logic [7:0]  sr_code,
	input  logic [7:0]  sd_code,
	input  logic        pop,
	output logic        res_valid,
	output result_t     res
);

	logic    valid_q;
	result_t res_q;
	result_t res_d;
	logic    is_sr;
	logic    is_sd;

	always_comb begin
		is_sr = rec.ptype == sr_code;
		is_sd = !is_sr && (rec.ptype == sd_code);
		res_d.version        = rec.header[7:6];
		res_d.padding        = rec.header[5];
		res_d.report_count   = rec.header[4:0];
		res_d.packet_type    = rec.ptype;
		res_d.length_words   = rec.len;
		res_d.ssrc           = (is_sr || is_sd) ? rec.ssrc : '0;
		res_d.ntp_timestamp  = is_sr ? rec.ntp : '0;
		res_d.rtp_timestamp  = is_sr ? rec.rtp : '0;
		res_d.sender_packets = is_sr ? rec.pkts : '0;
		res_d.sender_octets  = is_sr ? rec.octs : '0;
		res_d.sdes_item_type = is_sd ? rec.item : '0;
		res_d.truncated      = rec.truncated;
	end

	assign rec_take  = rec_valid && (!valid_q || pop);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (rec_take) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/rtcp_compound_packet_parser.sv =====
// top level of the rtcp compound packet parser
//
//  channel   handshake             word
//  input     push / full           data_byte, end_of_buffer
//  result    pop / empty           version .. truncated, one word per packet
//  config    psel/penable/pwrite   8-bit type codes at byte addresses 0 and 4
//
// one byte is taken every cycle while full is low; the record of the byte that ends a packet
// is written into the record queue and then registered in the result register
// full rises only when the record queue holds QUEUE_DEPTH packets
// reset clears the byte offset and empties the queue and the result register; codes go to 200 and 202
module rtcp_compound_packet_parser import rcpp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  version,
	output logic        padding,
	output logic [4:0]  report_count,
	output logic [7:0]  packet_type,
	output logic [15:0] length_words,
	output logic [31:0] ssrc,
	output logic [63:0] ntp_timestamp,
	output logic [31:0] rtp_timestamp,
	output logic [31:0] sender_packets,
	output logic [31:0] sender_octets,
	output logic [7:0]  sdes_item_type,
	output logic        truncated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]  sr_code_q;
	logic [7:0]  sd_code_q;
	logic        accept;
	logic        rec_push;
	packet_rec_t rec_in;
	packet_rec_t rec_out;
	logic        rec_take;
	logic        q_not_empty;
	logic        q_full;
	logic        res_valid;
	result_t     res;

	assign pready = 1'b1;
	assign prdata = {24'd0, (paddr[2] == CFG_IDX_SD) ? sd_code_q : sr_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_code_q <= SR_CODE_RST;
			sd_code_q <= SD_CODE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				CFG_IDX_SR: sr_code_q <= pwdata[7:0];
				CFG_IDX_SD: sd_code_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	rcpp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.rec_push      (rec_push),
		.rec           (rec_in)
	);

	rcpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rec_push),
		.wr_data   (rec_in),
		.rd        (rec_take),
		.rd_data   (rec_out),
		.not_empty (q_not_empty),
		.is_full   (q_full)
	);

	rcpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_not_empty),
		.rec       (rec_out),
		.rec_take  (rec_take),
		.sr_code   (sr_code_q),
		.sd_code   (sd_code_q),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign empty          = !res_valid;
	assign version        = res.version;
	assign padding        = res.padding;
	assign report_count   = res.report_count;
	assign packet_type    = res.packet_type;
	assign length_words   = res.length_words;
	assign ssrc           = res.ssrc;
	assign ntp_timestamp  = res.ntp_timestamp;
	assign rtp_timestamp  = res.rtp_timestamp;
	assign sender_packets = res.sender_packets;
	assign sender_octets  = res.sender_octets;
	assign sdes_item_type = res.sdes_item_type;
	assign truncated      = res.truncated;

endmodule

// ===== sv/rcpp_checker.sv =====
// port-level checks of the rtcp compound packet parser and their binding
module rcpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        end_of_buffer,
	input logic        empty,
	input logic        pop,
	input logic [15:0] length_words,
	input logic [31:0] ssrc,
	input logic        truncated
);

	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while no result is shown");

	a_eob_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && end_of_buffer |-> ##2 !empty)
		else $error("end of buffer byte gave no result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(length_words) && $stable(ssrc)
			&& $stable(truncated))
		else $error("stalled result word changed");

endmodule

bind rtcp_compound_packet_parser rcpp_checker u_rcpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.end_of_buffer (end_of_buffer),
	.empty         (empty),
	.pop           (pop),
	.length_words  (length_words),
	.ssrc          (ssrc),
	.truncated     (truncated)
);

// ===== dv/rcpp_report_checker.sv =====
// rtcp compound packet parser checker: predicts and compares reports and config reads
module rcpp_report_checker import rcpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  version,
	input  logic        padding,
	input  logic [4:0]  report_count,
	input  logic [7:0]  packet_type,
	input  logic [15:0] length_words,
	input  logic [31:0] ssrc,
	input  logic [63:0] ntp_timestamp,
	input  logic [31:0] rtp_timestamp,
	input  logic [31:0] sender_packets,
	input  logic [31:0] sender_octets,
	input  logic [7:0]  sdes_item_type,
	input  logic        truncated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          reports_pending
);

	logic [7:0]          sr_code;
	logic [7:0]          sd_code;

	logic [OFFSET_W-1:0] pkt_offset;
	logic [7:0]          hdr_acc;
	logic [7:0]          ptype_acc;
	logic [15:0]         len_acc;
	logic [31:0]         ssrc_acc;
	logic [63:0]         ntp_acc;
	logic [31:0]         rtp_acc;
	logic [31:0]         pkts_acc;
	logic [31:0]         octs_acc;
	logic [7:0]          item_acc;

	result_t             expected_reports[$];

	task automatic clear_packet_state();
		pkt_offset = '0;
		hdr_acc    = '0;
		ptype_acc  = '0;
		len_acc    = '0;
		ssrc_acc   = '0;
		ntp_acc    = '0;
		rtp_acc    = '0;
		pkts_acc   = '0;
		octs_acc   = '0;
		item_acc   = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic eob);
		logic [OFFSET_W-1:0] off;
		logic                done;
		logic                is_sr;
		logic                is_sd;
		result_t             r;
		off = pkt_offset;
		if (off == 0) begin
			hdr_acc = b;
		end else if (off == 1) begin
			ptype_acc = b;
		end else if (off == 2) begin
			len_acc[15:8] = b;
		end else if (off == 3) begin
			len_acc[7:0] = b;
		end else if (off <= 7) begin
			ssrc_acc[(7 - off) * 8 +: 8] = b;
		end else if (off <= 15) begin
			ntp_acc[(15 - off) * 8 +: 8] = b;
		end else if (off <= 19) begin
			rtp_acc[(19 - off) * 8 +: 8] = b;
		end else if (off <= 23) begin
			pkts_acc[(23 - off) * 8 +: 8] = b;
		end else if (off <= 27) begin
			octs_acc[(27 - off) * 8 +: 8] = b;
		end
		if (off == 8) begin
			item_acc = b;
		end
		done = (off >= 3) && (off == {len_acc, 2'b11});
		if (!done && !eob) begin
			pkt_offset = off + 1'b1;
		end else begin
			is_sr = (ptype_acc == sr_code);
			is_sd = !is_sr && (ptype_acc == sd_code);
			r.version        = hdr_acc[7:6];
			r.padding        = hdr_acc[5];
			r.report_count   = hdr_acc[4:0];
			r.packet_type    = ptype_acc;
			r.length_words   = len_acc;
			r.ssrc           = (is_sr || is_sd) ? ssrc_acc : '0;
			r.ntp_timestamp  = is_sr ? ntp_acc : '0;
			r.rtp_timestamp  = is_sr ? rtp_acc : '0;
			r.sender_packets = is_sr ? pkts_acc : '0;
			r.sender_octets  = is_sr ? octs_acc : '0;
			r.sdes_item_type = is_sd ? item_acc : '0;
			r.truncated      = !done;
			expected_reports.push_back(r);
			clear_packet_state();
		end
	endtask

	task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (a !== e) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			sr_code = SR_CODE_RST;
			sd_code = SD_CODE_RST;
			clear_packet_state();
			expected_reports.delete();
			mismatch_count  = 0;
			reports_pending = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_reports.size() == 0) begin
					$display("%0t unexpected word: expected none actual type %0h len %0h",
						$time, packet_type, length_words);
					mismatch_count++;
				end else begin
					exp_r = expected_reports.pop_front();
					cmp_field("version", exp_r.version, version);
					cmp_field("padding", exp_r.padding, padding);
					cmp_field("report_count", exp_r.report_count, report_count);
					cmp_field("packet_type", exp_r.packet_type, packet_type);
					cmp_field("length_words", exp_r.length_words, length_words);
					cmp_field("ssrc", exp_r.ssrc, ssrc);
					cmp_field("ntp_timestamp", exp_r.ntp_timestamp, ntp_timestamp);
					cmp_field("rtp_timestamp", exp_r.rtp_timestamp, rtp_timestamp);
					cmp_field("sender_packets", exp_r.sender_packets, sender_packets);
					cmp_field("sender_octets", exp_r.sender_octets, sender_octets);
					cmp_field("sdes_item_type", exp_r.sdes_item_type, sdes_item_type);
					cmp_field("truncated", exp_r.truncated, truncated);
				end
			end
			if (push && !full) begin
				parse_byte(data_byte, end_of_buffer);
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == CFG_IDX_SR) begin
						sr_code = pwdata[7:0];
					end else begin
						sd_code = pwdata[7:0];
					end
				end else begin
					cmp_field("prdata", {24'h0, (paddr[2] == CFG_IDX_SR) ? sr_code : sd_code},
						prdata);
				end
			end
			reports_pending = expected_reports.size();
		end
	end

endmodule

// ===== dv/tb_rtcp_compound_packet_parser.sv =====
// testbench top of the rtcp compound packet parser: stimulus, reset, clock and verdict
module tb_rtcp_compound_packet_parser;
	import rcpp_pkg::*;

	localparam logic [2:0] SR_ADDR = {CFG_IDX_SR, 2'b00};
	localparam logic [2:0] SD_ADDR = {CFG_IDX_SD, 2'b00};
	localparam int         PHASE_BYTES = 220;
	localparam int         HOLD_PHASE = 2;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_buffer;
	logic        empty;
	logic        pop;
	logic [1:0]  version;
	logic        padding;
	logic [4:0]  report_count;
	logic [7:0]  packet_type;
	logic [15:0] length_words;
	logic [31:0] ssrc;
	logic [63:0] ntp_timestamp;
	logic [31:0] rtp_timestamp;
	logic [31:0] sender_packets;
	logic [31:0] sender_octets;
	logic [7:0]  sdes_item_type;
	logic        truncated;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatch_count;
	int          reports_pending;

	logic [7:0]  cur_sr;
	logic [7:0]  cur_sd;
	logic [8:0]  byte_stream[$];
	int          phase_no;
	int          burst_left;

	rtcp_compound_packet_parser dut (.*);

	rcpp_report_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAIL rtcp_compound_packet_parser");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// well-formed packet with random content, sometimes cut short, or a burst of noise
	task automatic gen_packet();
		int         r;
		int         len;
		int         n;
		int         cut;
		logic       last_eob;
		logic [7:0] ptype;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 30);
			for (int i = 0; i < n; i++) begin
				byte_stream.push_back({(i == n - 1) || ($urandom_range(0, 15) == 0), rand_byte()});
			end
		end else begin
			r = $urandom_range(0, 99);
			ptype = (r < 40) ? cur_sr : (r < 70) ? cur_sd : rand_byte();
			if ($urandom_range(0, 19) == 0) begin
				len = $urandom_range(9, 80);
			end else if (ptype == cur_sr && $urandom_range(0, 2) != 0) begin
				len = 6 + $urandom_range(0, 3);
			end else begin
				len = $urandom_range(0, 8);
			end
			n = 4 * (len + 1);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n - 1;
			last_eob = (cut < n - 1) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i <= cut; i++) begin
				case (i)
					0: b = rand_byte();
					1: b = ptype;
					2: b = len[15:8];
					3: b = len[7:0];
					default: b = rand_byte();
				endcase
				byte_stream.push_back({(i == cut) && last_eob, b});
			end
		end
	endtask

	task automatic send_byte(input logic [8:0] w);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(40, 160);
		end
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push          <= 1'b1;
		data_byte     <= w[7:0];
		end_of_buffer <= w[8];
		do @(posedge clk); while (full);
	endtask

	task automatic send_bytes(input int count);
		repeat (count) begin
			if (byte_stream.size() == 0) gen_packet();
			send_byte(byte_stream.pop_front());
		end
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (reports_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [2:0] a, input logic [7:0] v);
		logic [31:0] w;
		w = $urandom;
		w[7:0] = v;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= w;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [7:0] sr_set[6];
		logic [7:0] sd_set[6];
		push          = 1'b0;
		data_byte     = '0;
		end_of_buffer = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		arst_n        = 1'b0;
		phase_no      = 0;
		burst_left    = 0;
		cur_sr        = SR_CODE_RST;
		cur_sd        = SD_CODE_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		reg_access(1'b0, SR_ADDR, '0);
		reg_access(1'b0, SD_ADDR, '0);

		// buffer ending on the first header byte
		byte_stream.push_back({1'b1, 8'hFF});
		// complete source description
		byte_stream.push_back({1'b0, 8'h81});
		byte_stream.push_back({1'b0, SD_CODE_RST});
		byte_stream.push_back({1'b0, 8'h00});
		byte_stream.push_back({1'b0, 8'h02});
		byte_stream.push_back({1'b0, 8'hDE});
		byte_stream.push_back({1'b0, 8'hAD});
		byte_stream.push_back({1'b0, 8'hBE});
		byte_stream.push_back({1'b0, 8'hEF});
		byte_stream.push_back({1'b0, 8'h01});
		byte_stream.push_back({1'b0, 8'h05});
		byte_stream.push_back({1'b0, 8'h61});
		byte_stream.push_back({1'b0, 8'h62});
		// sender report whose length ends it inside the body
		byte_stream.push_back({1'b0, 8'h80});
		byte_stream.push_back({1'b0, SR_CODE_RST});
		byte_stream.push_back({1'b0, 8'h00});
		byte_stream.push_back({1'b0, 8'h01});
		byte_stream.push_back({1'b0, 8'h12});
		byte_stream.push_back({1'b0, 8'h34});
		byte_stream.push_back({1'b0, 8'h56});
		byte_stream.push_back({1'b0, 8'h78});
		// greatest length, cut off right after the length field
		byte_stream.push_back({1'b0, 8'h3F});
		byte_stream.push_back({1'b0, 8'h00});
		byte_stream.push_back({1'b0, 8'hFF});
		byte_stream.push_back({1'b1, 8'hFF});
		send_bytes(byte_stream.size());
		settle();

		sr_set = '{SR_CODE_RST, 8'h00, 8'hFF, 8'd77, rand_byte(), SR_CODE_RST};
		sd_set = '{SD_CODE_RST, 8'hFF, 8'h00, 8'd77, rand_byte(), SD_CODE_RST};
		if ($urandom_range(0, 1) == 0) sd_set[4] = sr_set[4];
		for (int p = 0; p < 6; p++) begin
			phase_no = p + 1;
			cur_sr = sr_set[p];
			cur_sd = sd_set[p];
			reg_access(1'b1, SR_ADDR, cur_sr);
			reg_access(1'b1, SD_ADDR, cur_sd);
			reg_access(1'b0, SR_ADDR, '0);
			reg_access(1'b0, SD_ADDR, '0);
			send_bytes(PHASE_BYTES);
			settle();
		end

		send_bytes(byte_stream.size());
		send_byte({1'b1, rand_byte()});
		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && reports_pending == 0) begin
			$display("PASS rtcp_compound_packet_parser");
		end else begin
			$display("FAIL rtcp_compound_packet_parser");
		end
		$finish;
	end

	initial begin
		int gap;
		bit held;
		pop  = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			// long hold-off so the parser backs up and stalls its input
			if (phase_no == HOLD_PHASE && !held) begin
				held = 1'b1;
				repeat (500) begin
					@(negedge clk);
					pop <= 1'b0;
				end
			end
		end
	end

endmodule
